>>> rtl/core/cexe_pkg.sv
// Shared types and codes for the 16-bit integer execute block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package cexe_pkg;

    // Operation codes.
    localparam logic [2:0] KIND_MOV = 3'd0;
    localparam logic [2:0] KIND_ADD = 3'd1;
    localparam logic [2:0] KIND_SUB = 3'd2;
    localparam logic [2:0] KIND_CMP = 3'd3;
    localparam logic [2:0] KIND_JNE = 3'd4;

    // Source operand codes.
    localparam logic [1:0] SRC_REG   = 2'd0;
    localparam logic [1:0] SRC_IMM8  = 2'd1;
    localparam logic [1:0] SRC_IMM16 = 2'd2;
    localparam logic [1:0] SRC_MEM   = 2'd3;

    // Address base codes.
    localparam logic [3:0] BASE_BX_SI  = 4'd0;
    localparam logic [3:0] BASE_BX_DI  = 4'd1;
    localparam logic [3:0] BASE_BP_SI  = 4'd2;
    localparam logic [3:0] BASE_BP_DI  = 4'd3;
    localparam logic [3:0] BASE_SI     = 4'd4;
    localparam logic [3:0] BASE_DI     = 4'd5;
    localparam logic [3:0] BASE_BP     = 4'd6;
    localparam logic [3:0] BASE_BX     = 4'd7;
    localparam logic [3:0] BASE_DIRECT = 4'd8;

    // Word register indexes used for address generation.
    localparam logic [2:0] REG_BX = 3'd3;
    localparam logic [2:0] REG_BP = 3'd5;
    localparam logic [2:0] REG_SI = 3'd6;
    localparam logic [2:0] REG_DI = 3'd7;

    localparam logic [15:0] WORD_HI_MASK = 16'hFF00;
    localparam logic [15:0] WORD_LO_MASK = 16'h00FF;
    localparam logic [7:0]  BYTE_ONES    = 8'hFF;

    typedef logic [7:0][15:0] t_regfile;

    // One decoded instruction as it arrives.
    typedef struct packed {
        logic [2:0]  kind;
        logic        dest_is_reg;
        logic [3:0]  dest_reg;
        logic [1:0]  src_kind;
        logic [3:0]  src_reg;
        logic [3:0]  addr_mode;
        logic [15:0] mem_offset;
        logic [15:0] immediate;
        logic [15:0] jump_offset;
    } t_instr;

    // Instruction after address generation and width decode.
    typedef struct packed {
        logic [2:0]  kind;
        logic        dest_is_reg;
        logic [3:0]  dest_reg;
        logic [1:0]  src_kind;
        logic [3:0]  src_reg;
        logic [15:0] immediate;
        logic [15:0] jump_offset;
        logic [15:0] ea;
        logic        wide;
        logic        fault;
        logic        uses_mem;
    } t_exec;

endpackage

>>> rtl/core/cexe_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cexe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/core/cpu_execute_mov_add_sub_cmp_jne.sv
// Execute block for a 16-bit integer subset: MOV, ADD, SUB, CMP and JNE.
// Depends on cexe_pkg and on cexe_ram for the two data memory banks.
`timescale 1ns / 1ps

// Usage
// The input channel (i_valid / o_ready) takes one decoded instruction word per
// handshake. The output channel (o_valid / i_ready) returns one result word per
// instruction, in order, carrying the value, the effective address, the flags,
// the instruction pointer after the instruction and a fault bit.
// Each instruction passes through address generation, where it issues the
// memory reads, and then execute, where it uses the read data and writes
// back; the result is then registered in the output register. The next word
// waits in address generation while the one ahead executes, since it may need
// the registers or memory bytes that one writes, so a word leaves address
// generation only once execute is empty. The data memory is split into
// even and odd byte banks so a word at any address is read or written whole.
// After reset every register, flag and the instruction pointer are zero, and a
// clearing pass zeroes the data memory one row of both banks per cycle, with
// o_ready held low until the pass ends.
// When the receiver stalls, the result waits in the output register; one word
// can wait in execute and one more in address generation behind it, and then
// o_ready drops.

module cpu_execute_mov_add_sub_cmp_jne
    import cexe_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Instruction channel.
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_kind,
    input  logic               i_dest_is_reg,
    input  logic [3:0]         i_dest_reg,
    input  logic [1:0]         i_src_kind,
    input  logic [3:0]         i_src_reg,
    input  logic [3:0]         i_addr_mode,
    input  logic [15:0]        i_mem_offset,
    input  logic [15:0]        i_immediate,
    input  logic signed [15:0] i_jump_offset,
    // Result channel.
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_result_value,
    output logic [15:0]        o_effective_address,
    output logic               o_zero_flag,
    output logic               o_sign_flag,
    output logic [15:0]        o_next_ip,
    output logic               o_fault
);

    localparam int ROW_BITS = ADDR_BITS - 1;
    localparam int ROWS     = 2 ** ROW_BITS;

    // Architectural state held in flip-flops.
    t_regfile    r_regs;
    logic        r_zf;
    logic        r_sf;
    logic [15:0] r_ip;

    // Memory clearing pass after reset.
    logic                r_clr_busy;
    logic [ROW_BITS-1:0] r_clr_row;

    // Pipeline stages.
    logic   r_a_valid;
    t_instr r_a;
    logic   r_b_valid;
    t_exec  r_b;
    logic   r_out_valid;

    logic a_go;
    logic b_go;

    // Reads a register by its byte or word code.
    function automatic logic [15:0] reg_get(input t_regfile regs, input logic [3:0] code);
        logic [15:0] v;
        if (code[3]) begin
            v = regs[code[2:0]];
        end else if (code[2]) begin
            v = {8'h00, regs[{1'b0, code[1:0]}][15:8]};
        end else begin
            v = {8'h00, regs[{1'b0, code[1:0]}][7:0]};
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    // Address generation moves on only when execute is empty, so it sees the
    // registers and memory after the previous instruction wrote them.
    assign a_go    = r_a_valid && !r_b_valid;
    assign b_go    = r_b_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_clr_busy && (!r_a_valid || a_go);
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_a_valid <= 1'b1;
            end else if (a_go) begin
                r_a_valid <= 1'b0;
            end
            if (a_go) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
            if (b_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a.kind        <= i_kind;
            r_a.dest_is_reg <= i_dest_is_reg;
            r_a.dest_reg    <= i_dest_reg;
            r_a.src_kind    <= i_src_kind;
            r_a.src_reg     <= i_src_reg;
            r_a.addr_mode   <= i_addr_mode;
            r_a.mem_offset  <= i_mem_offset;
            r_a.immediate   <= i_immediate;
            r_a.jump_offset <= i_jump_offset;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: width decode and effective address
    // ------------------------------------------------------------------
    logic [15:0]          a_base;
    logic [15:0]          a_ea;
    logic [15:0]          a_ea_next;
    logic                 a_wide;
    logic                 a_no_width;
    logic [ADDR_BITS-1:0] a_lo_idx;
    logic [ADDR_BITS-1:0] a_hi_idx;
    t_exec                a_exec;

    always_comb begin
        unique case (r_a.addr_mode)
            BASE_BX_SI: a_base = r_regs[REG_BX] + r_regs[REG_SI];
            BASE_BX_DI: a_base = r_regs[REG_BX] + r_regs[REG_DI];
            BASE_BP_SI: a_base = r_regs[REG_BP] + r_regs[REG_SI];
            BASE_BP_DI: a_base = r_regs[REG_BP] + r_regs[REG_DI];
            BASE_SI:    a_base = r_regs[REG_SI];
            BASE_DI:    a_base = r_regs[REG_DI];
            BASE_BP:    a_base = r_regs[REG_BP];
            BASE_BX:    a_base = r_regs[REG_BX];
            default:    a_base = 16'h0000;
        endcase
        a_ea      = a_base + r_a.mem_offset;
        a_ea_next = a_ea + 16'd1;
        a_lo_idx  = ADDR_BITS'(a_ea);
        a_hi_idx  = ADDR_BITS'(a_ea_next);

        a_wide     = 1'b0;
        a_no_width = 1'b0;
        if (r_a.dest_is_reg) begin
            a_wide = r_a.dest_reg[3];
        end else begin
            unique case (r_a.src_kind)
                SRC_REG:   a_wide = r_a.src_reg[3];
                SRC_IMM8:  a_wide = 1'b0;
                SRC_IMM16: a_wide = 1'b1;
                SRC_MEM:   a_no_width = 1'b1;
                default:   a_no_width = 1'b1;
            endcase
        end

        a_exec.kind        = r_a.kind;
        a_exec.dest_is_reg = r_a.dest_is_reg;
        a_exec.dest_reg    = r_a.dest_reg;
        a_exec.src_kind    = r_a.src_kind;
        a_exec.src_reg     = r_a.src_reg;
        a_exec.immediate   = r_a.immediate;
        a_exec.jump_offset = r_a.jump_offset;
        a_exec.ea          = a_ea;
        a_exec.wide        = a_wide;
        a_exec.fault       = a_no_width && (r_a.kind <= KIND_CMP);
        a_exec.uses_mem    = !r_a.dest_is_reg || (r_a.src_kind == SRC_MEM);
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b <= a_exec;
        end
    end

    // ------------------------------------------------------------------
    // Data memory: even and odd byte banks
    // ------------------------------------------------------------------
    logic                 b_lo_par;
    logic [ROW_BITS-1:0]  b_lo_row;
    logic [ROW_BITS-1:0]  b_hi_row;
    logic [ADDR_BITS-1:0] b_lo_idx;
    logic [ADDR_BITS-1:0] b_hi_idx;
    logic [15:0]          b_ea_next;

    logic                even_we;
    logic                odd_we;
    logic [ROW_BITS-1:0] even_waddr;
    logic [ROW_BITS-1:0] odd_waddr;
    logic [7:0]          even_wdata;
    logic [7:0]          odd_wdata;
    logic [ROW_BITS-1:0] even_raddr;
    logic [ROW_BITS-1:0] odd_raddr;
    logic [7:0]          even_rdata;
    logic [7:0]          odd_rdata;
    logic                wr_mem;
    logic [15:0]         n_result;

    assign even_raddr = a_lo_idx[0] ? a_hi_idx[ADDR_BITS-1:1] : a_lo_idx[ADDR_BITS-1:1];
    assign odd_raddr  = a_lo_idx[0] ? a_lo_idx[ADDR_BITS-1:1] : a_hi_idx[ADDR_BITS-1:1];

    assign b_ea_next = r_b.ea + 16'd1;
    assign b_lo_idx  = ADDR_BITS'(r_b.ea);
    assign b_hi_idx  = ADDR_BITS'(b_ea_next);
    assign b_lo_par  = b_lo_idx[0];
    assign b_lo_row  = b_lo_idx[ADDR_BITS-1:1];
    assign b_hi_row  = b_hi_idx[ADDR_BITS-1:1];

    // The low and high bytes of a word always fall in different banks.
    always_comb begin
        if (r_clr_busy) begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_waddr = r_clr_row;
            odd_waddr  = r_clr_row;
            even_wdata = 8'h00;
            odd_wdata  = 8'h00;
        end else begin
            even_we    = wr_mem && (!b_lo_par || r_b.wide);
            odd_we     = wr_mem && (b_lo_par || r_b.wide);
            even_waddr = b_lo_par ? b_hi_row : b_lo_row;
            odd_waddr  = b_lo_par ? b_lo_row : b_hi_row;
            even_wdata = b_lo_par ? n_result[15:8] : n_result[7:0];
            odd_wdata  = b_lo_par ? n_result[7:0] : n_result[15:8];
        end
    end

    cexe_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (even_we),
        .i_waddr (even_waddr),
        .i_wdata (even_wdata),
        .i_re    (a_go),
        .i_raddr (even_raddr),
        .o_rdata (even_rdata)
    );

    cexe_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (odd_we),
        .i_waddr (odd_waddr),
        .i_wdata (odd_wdata),
        .i_re    (a_go),
        .i_raddr (odd_raddr),
        .o_rdata (odd_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (&r_clr_row) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: execute and write back
    // ------------------------------------------------------------------
    logic [15:0] b_mask;
    logic [15:0] b_mem_val;
    logic [15:0] b_sv;
    logic [15:0] b_dv;
    logic [15:0] b_sign_bit;
    logic        b_is_alu;
    logic        b_exec_ok;
    logic        n_zf;
    logic        n_sf;
    logic [15:0] n_ip;
    logic [15:0] n_ea_out;

    always_comb begin
        b_mask     = r_b.wide ? (WORD_HI_MASK | WORD_LO_MASK) : WORD_LO_MASK;
        b_sign_bit = r_b.wide ? 16'h8000 : 16'h0080;
        b_mem_val  = b_lo_par ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};
        if (!r_b.wide) begin
            b_mem_val = {8'h00, b_mem_val[7:0] & BYTE_ONES};
        end

        case (r_b.src_kind)
            SRC_REG: b_sv = reg_get(r_regs, r_b.src_reg);
            SRC_MEM: b_sv = b_mem_val;
            default: b_sv = r_b.immediate;
        endcase
        b_sv = b_sv & b_mask;
        b_dv = (r_b.dest_is_reg ? reg_get(r_regs, r_b.dest_reg) : b_mem_val) & b_mask;

        b_is_alu  = r_b.kind <= KIND_CMP;
        b_exec_ok = b_is_alu && !r_b.fault;

        n_result = 16'h0000;
        n_zf     = r_zf;
        n_sf     = r_sf;
        n_ip     = r_ip;
        if (b_exec_ok) begin
            case (r_b.kind)
                KIND_MOV: n_result = b_sv;
                KIND_ADD: n_result = (b_dv + b_sv) & b_mask;
                default:  n_result = (b_dv - b_sv) & b_mask;
            endcase
            if (r_b.kind != KIND_MOV) begin
                n_zf = (n_result == 16'h0000);
                n_sf = |(n_result & b_sign_bit);
            end
        end else if (r_b.kind == KIND_JNE && !r_zf) begin
            n_ip = r_ip + r_b.jump_offset;
        end

        n_ea_out = (b_exec_ok && r_b.uses_mem) ? r_b.ea : 16'h0000;
    end

    assign wr_mem = b_go && b_exec_ok && (r_b.kind != KIND_CMP) && !r_b.dest_is_reg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
            r_zf   <= 1'b0;
            r_sf   <= 1'b0;
            r_ip   <= 16'h0000;
        end else if (b_go) begin
            r_zf <= n_zf;
            r_sf <= n_sf;
            r_ip <= n_ip;
            if (b_exec_ok && (r_b.kind != KIND_CMP) && r_b.dest_is_reg) begin
                if (r_b.dest_reg[3]) begin
                    r_regs[r_b.dest_reg[2:0]] <= n_result;
                end else if (r_b.dest_reg[2]) begin
                    r_regs[{1'b0, r_b.dest_reg[1:0]}][15:8] <= n_result[7:0];
                end else begin
                    r_regs[{1'b0, r_b.dest_reg[1:0]}][7:0] <= n_result[7:0];
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (b_go) begin
            o_result_value      <= n_result;
            o_effective_address <= n_ea_out;
            o_zero_flag         <= n_zf;
            o_sign_flag         <= n_sf;
            o_next_ip           <= n_ip;
            o_fault             <= r_b.fault;
        end
    end

`ifndef SYNTHESIS
    // A memory read must never be issued while an older instruction can still write.
    a_no_read_under_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_go |-> !r_b_valid)
        else $error("memory read issued while execute stage is occupied");

    // No instruction is taken while the memory is being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_ready && !r_a_valid && !r_b_valid)
        else $error("instruction activity during memory clearing pass");

    // Both banks written by an instruction only for a word store.
    a_word_store_both_banks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_clr_busy && even_we && odd_we) |-> r_b.wide && wr_mem)
        else $error("byte store wrote both banks");

    // The instruction pointer moves only on a jump.
    a_ip_only_on_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_go && r_b.kind != KIND_JNE) |=> r_ip == $past(r_ip))
        else $error("instruction pointer changed by a non-jump instruction");

    // A faulting instruction reports no value and no address.
    a_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault) |-> (o_result_value == 16'h0000 && o_effective_address == 16'h0000))
        else $error("faulting instruction reported a value or address");
`endif

endmodule

>>> tb/cexe_check_pkg.sv
// Result record, register codes and the execute-stage scoreboard for the testbench.
// Depends on cexe_pkg for the instruction layout and the operation, source and base codes.
`timescale 1ns / 1ps

package cexe_check_pkg;

    import cexe_pkg::*;

    localparam int ADDR_BITS = 16;
    localparam int MEM_BYTES = 1 << ADDR_BITS;
    localparam int MAX_REPORTS = 10;

    // Register codes as the instruction word carries them.
    localparam logic [3:0] R_AL = 4'd0;
    localparam logic [3:0] R_BL = 4'd3;
    localparam logic [3:0] R_AH = 4'd4;
    localparam logic [3:0] R_DH = 4'd6;
    localparam logic [3:0] R_BH = 4'd7;
    localparam logic [3:0] R_AX = 4'd8;
    localparam logic [3:0] R_CX = 4'd9;
    localparam logic [3:0] R_BX = 4'd11;
    localparam logic [3:0] R_BP = 4'd13;
    localparam logic [3:0] R_SI = 4'd14;
    localparam logic [3:0] R_DI = 4'd15;

    // Codes that the block treats as no operation or as a zero base.
    localparam logic [2:0] KIND_NONE_LO = 3'd5;
    localparam logic [2:0] KIND_NONE_HI = 3'd7;
    localparam logic [3:0] BASE_NONE_LO = 4'd9;
    localparam logic [3:0] BASE_NONE_HI = 4'd15;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] ea;
        logic        zf;
        logic        sf;
        logic [15:0] ip;
        logic        fault;
    } t_outcome;

    class exec_scoreboard;
        bit [15:0] regs [8];
        bit [7:0]  mem [MEM_BYTES];
        bit        zf;
        bit        sf;
        bit [15:0] ip;
        t_outcome  outcomes_due [$];
        int        errors;
        int        words_seen;
        int        results_seen;
        int        faults_seen;
        int        jumps_taken;

        function int pending();
            return outcomes_due.size();
        endfunction

        function logic [15:0] read_reg(logic [3:0] code);
            if (code[3]) return regs[code[2:0]];
            if (code[2]) return {8'h00, regs[{1'b0, code[1:0]}][15:8]};
            return {8'h00, regs[{1'b0, code[1:0]}][7:0]};
        endfunction

        // Byte writes keep the other half of the register.
        function void write_reg(logic [3:0] code, logic [15:0] v);
            if (code[3]) begin
                regs[code[2:0]] = v;
            end else if (code[2]) begin
                regs[{1'b0, code[1:0]}] = (regs[{1'b0, code[1:0]}] & WORD_LO_MASK)
                                          | {v[7:0], 8'h00};
            end else begin
                regs[{1'b0, code[1:0]}] = (regs[{1'b0, code[1:0]}] & WORD_HI_MASK)
                                          | {8'h00, v[7:0]};
            end
        endfunction

        function logic [ADDR_BITS-1:0] slot(logic [15:0] a);
            return ADDR_BITS'(a);
        endfunction

        // Little-endian; the second byte address wraps at 16 bits.
        function logic [15:0] load(logic [15:0] a, logic wide);
            logic [15:0] a_hi;
            a_hi = a + 16'd1;
            if (!wide) return {8'h00, mem[slot(a)]};
            return {mem[slot(a_hi)], mem[slot(a)]};
        endfunction

        function void store(logic [15:0] a, logic [15:0] v, logic wide);
            logic [15:0] a_hi;
            a_hi = a + 16'd1;
            mem[slot(a)] = v[7:0];
            if (wide) mem[slot(a_hi)] = v[15:8];
        endfunction

        function logic [15:0] address_of(logic [3:0] base, logic [15:0] off);
            logic [15:0] b;
            case (base)
                BASE_BX_SI: b = regs[REG_BX] + regs[REG_SI];
                BASE_BX_DI: b = regs[REG_BX] + regs[REG_DI];
                BASE_BP_SI: b = regs[REG_BP] + regs[REG_SI];
                BASE_BP_DI: b = regs[REG_BP] + regs[REG_DI];
                BASE_SI:    b = regs[REG_SI];
                BASE_DI:    b = regs[REG_DI];
                BASE_BP:    b = regs[REG_BP];
                BASE_BX:    b = regs[REG_BX];
                default:    b = '0;
            endcase
            return b + off;
        endfunction

        // Executes one accepted word on the tracked state and queues what it must return.
        function void note_word(t_instr w);
            t_outcome    o;
            logic        wide;
            logic        uses_mem;
            logic [15:0] mask;
            logic [15:0] addr;
            logic [15:0] sv;
            logic [15:0] dv;
            logic [15:0] res;
            o = '0;
            wide = 1'b0;
            words_seen++;
            if (w.kind == KIND_JNE) begin
                if (!zf) begin
                    ip = ip + w.jump_offset;
                    jumps_taken++;
                end
            end else if (w.kind <= KIND_CMP) begin
                if (w.dest_is_reg) begin
                    wide = w.dest_reg[3];
                end else begin
                    case (w.src_kind)
                        SRC_REG:   wide = w.src_reg[3];
                        SRC_IMM8:  wide = 1'b0;
                        SRC_IMM16: wide = 1'b1;
                        default:   o.fault = 1'b1;
                    endcase
                end
                if (o.fault) begin
                    faults_seen++;
                end else begin
                    mask = wide ? 16'hFFFF : WORD_LO_MASK;
                    uses_mem = !w.dest_is_reg || w.src_kind == SRC_MEM;
                    addr = address_of(w.addr_mode, w.mem_offset);
                    if (uses_mem) o.ea = addr;
                    case (w.src_kind)
                        SRC_REG: sv = read_reg(w.src_reg);
                        SRC_MEM: sv = load(addr, wide);
                        default: sv = w.immediate;
                    endcase
                    sv &= mask;
                    if (w.kind == KIND_MOV) begin
                        res = sv;
                    end else begin
                        dv = (w.dest_is_reg ? read_reg(w.dest_reg) : load(addr, wide)) & mask;
                        res = ((w.kind == KIND_ADD) ? dv + sv : dv - sv) & mask;
                        zf = (res == '0);
                        sf = wide ? res[15] : res[7];
                    end
                    if (w.kind != KIND_CMP) begin
                        if (w.dest_is_reg) write_reg(w.dest_reg, res);
                        else store(addr, res, wide);
                    end
                    o.value = res;
                end
            end
            o.zf = zf;
            o.sf = sf;
            o.ip = ip;
            outcomes_due.push_back(o);
        endfunction

        function void tally(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("%s", what);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                tally($sformatf("mismatch in result %0d, %s: expected 0x%h, got 0x%h",
                                results_seen, field, want, got));
            end
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            results_seen++;
            if (outcomes_due.size() == 0) begin
                tally($sformatf("result %0d arrived with no word outstanding", results_seen));
                return;
            end
            want = outcomes_due.pop_front();
            compare("result_value", want.value, got.value);
            compare("effective_address", want.ea, got.ea);
            compare("zero_flag", 16'(want.zf), 16'(got.zf));
            compare("sign_flag", 16'(want.sf), 16'(got.sf));
            compare("next_ip", want.ip, got.ip);
            compare("fault", 16'(want.fault), 16'(got.fault));
        endfunction
    endclass

endpackage

>>> tb/tb_cpu_execute_mov_add_sub_cmp_jne.sv
// Top-level testbench for the MOV/ADD/SUB/CMP/JNE execute block: clock, reset, drivers,
// monitor and watchdog. Depends on cexe_pkg, cexe_check_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_cpu_execute_mov_add_sub_cmp_jne
    import cexe_pkg::*;
    import cexe_check_pkg::*;
();

    localparam int RANDOM_WORDS = 1150;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b1;
    logic o_ready;
    logic o_valid;

    // The word on offer lives in one struct; the payload ports follow it.
    t_instr word_q = '0;

    logic [2:0]         i_kind;
    logic               i_dest_is_reg;
    logic [3:0]         i_dest_reg;
    logic [1:0]         i_src_kind;
    logic [3:0]         i_src_reg;
    logic [3:0]         i_addr_mode;
    logic [15:0]        i_mem_offset;
    logic [15:0]        i_immediate;
    logic signed [15:0] i_jump_offset;

    logic [15:0] o_result_value;
    logic [15:0] o_effective_address;
    logic        o_zero_flag;
    logic        o_sign_flag;
    logic [15:0] o_next_ip;
    logic        o_fault;

    assign i_kind        = word_q.kind;
    assign i_dest_is_reg = word_q.dest_is_reg;
    assign i_dest_reg    = word_q.dest_reg;
    assign i_src_kind    = word_q.src_kind;
    assign i_src_reg     = word_q.src_reg;
    assign i_addr_mode   = word_q.addr_mode;
    assign i_mem_offset  = word_q.mem_offset;
    assign i_immediate   = word_q.immediate;
    assign i_jump_offset = word_q.jump_offset;

    exec_scoreboard sb;

    // While steady is set, neither side starts random idle cycles.
    bit steady = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    cpu_execute_mov_add_sub_cmp_jne #(
        .ADDR_BITS(ADDR_BITS)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_kind             (i_kind),
        .i_dest_is_reg      (i_dest_is_reg),
        .i_dest_reg         (i_dest_reg),
        .i_src_kind         (i_src_kind),
        .i_src_reg          (i_src_reg),
        .i_addr_mode        (i_addr_mode),
        .i_mem_offset       (i_mem_offset),
        .i_immediate        (i_immediate),
        .i_jump_offset      (i_jump_offset),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_result_value     (o_result_value),
        .o_effective_address(o_effective_address),
        .o_zero_flag        (o_zero_flag),
        .o_sign_flag        (o_sign_flag),
        .o_next_ip          (o_next_ip),
        .o_fault            (o_fault)
    );

    function automatic t_instr make_word(logic [2:0] kind, logic dest_is_reg, logic [3:0] dest_reg,
                                         logic [1:0] src_kind, logic [3:0] src_reg,
                                         logic [3:0] base, logic [15:0] offset,
                                         logic [15:0] imm, logic [15:0] jump);
        t_instr w;
        w.kind        = kind;
        w.dest_is_reg = dest_is_reg;
        w.dest_reg    = dest_reg;
        w.src_kind    = src_kind;
        w.src_reg     = src_reg;
        w.addr_mode   = base;
        w.mem_offset  = offset;
        w.immediate   = imm;
        w.jump_offset = jump;
        return w;
    endfunction

    // Random instruction. Offsets lean toward a small window and toward the top of
    // the address space so that memory bytes get written and then read back, and
    // about one word in ten loads a pointer register with a small value so that the
    // based addressing modes keep landing in that window.
    function automatic t_instr random_word();
        t_instr      w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) w.kind = 3'($urandom_range(KIND_NONE_LO, KIND_NONE_HI));
        else if (pick < 16) w.kind = KIND_JNE;
        else w.kind = 3'($urandom_range(KIND_MOV, KIND_CMP));
        w.dest_is_reg = ($urandom_range(0, 9) < 7);
        w.dest_reg    = 4'($urandom_range(0, 15));
        w.src_kind    = 2'($urandom_range(SRC_REG, SRC_MEM));
        w.src_reg     = ($urandom_range(0, 9) == 0) ? w.dest_reg : 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 70) w.addr_mode = 4'($urandom_range(BASE_BX_SI, BASE_BX));
        else if (pick < 90) w.addr_mode = BASE_DIRECT;
        else w.addr_mode = 4'($urandom_range(BASE_NONE_LO, BASE_NONE_HI));
        pick = $urandom_range(0, 99);
        if (pick < 40) w.mem_offset = 16'($urandom_range(0, 31));
        else if (pick < 50) w.mem_offset = 16'hFFF0 + 16'($urandom_range(0, 15));
        else w.mem_offset = 16'($urandom_range(0, 16'hFFFF));
        w.immediate   = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3))
                                                    : 16'($urandom_range(0, 16'hFFFF));
        w.jump_offset = 16'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 9) == 0) begin
            w.kind        = KIND_MOV;
            w.dest_is_reg = 1'b1;
            case ($urandom_range(0, 3))
                0: w.dest_reg = R_BX;
                1: w.dest_reg = R_BP;
                2: w.dest_reg = R_SI;
                default: w.dest_reg = R_DI;
            endcase
            w.src_kind  = SRC_IMM16;
            w.immediate = 16'($urandom_range(0, 63));
        end
        return w;
    endfunction

    // Offers one word and returns in the time step of the edge that accepts it.
    // Valid is only raised here, so a word that follows directly keeps it high.
    task automatic send_word(t_instr w);
        i_valid <= 1'b1;
        word_q  <= w;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle_cycles(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Holds the sender off until every accepted word has returned its result.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Receiver: outside steady stretches a stall starts with a chance of two percent
    // at each edge, so results sit in the output register for varying spans.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < 2) begin
            stall_left <= $urandom_range(0, 4);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: both handshakes are sampled at the edge, before any driver update
    // lands. A result never belongs to the word accepted at the same edge, since
    // a word passes address generation and execute before its result is registered, so noting before checking is safe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_word(word_q);
            if (o_valid && i_ready) begin
                sb.check_result('{value: o_result_value, ea: o_effective_address,
                                  zf: o_zero_flag, sf: o_sign_flag, ip: o_next_ip,
                                  fault: o_fault});
            end
            // The limit covers the memory clearing pass after reset with a wide margin.
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved in %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, sb.pending());
                $display("RESULT: ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Starting from the all-zero state it covers the word and
        // both byte halves of registers, a word stored at the top address whose
        // second byte wraps to address zero, every operation, a compare that sets
        // the zero flag followed by a jump that is not taken, taken jumps with the
        // largest positive and negative offsets and the IP wrapping, the width
        // coming from the source register or the immediate size, faulting
        // memory-to-memory MOV and CMP, two unused operation codes and an unused base code.
        send_word(make_word(KIND_MOV, 1'b1, R_AX, SRC_IMM16, R_AL, BASE_DIRECT, '0,
                            16'hFFFF, '0));
        send_word(make_word(KIND_MOV, 1'b1, R_AH, SRC_IMM8, R_AL, BASE_DIRECT, '0,
                            16'hFF12, '0));
        send_word(make_word(KIND_MOV, 1'b1, R_BL, SRC_REG, R_AH, BASE_DIRECT, '0, '0, '0));
        send_word(make_word(KIND_MOV, 1'b1, R_SI, SRC_IMM16, R_AL, BASE_DIRECT, '0,
                            16'h0001, '0));
        send_word(make_word(KIND_MOV, 1'b1, R_DI, SRC_IMM16, R_AL, BASE_DIRECT, '0,
                            16'h8000, '0));
        send_word(make_word(KIND_MOV, 1'b1, R_BP, SRC_IMM16, R_AL, BASE_DIRECT, '0,
                            16'hFFFF, '0));
        send_word(make_word(KIND_MOV, 1'b0, R_AL, SRC_IMM16, R_AL, BASE_DIRECT, 16'hFFFF,
                            16'hABCD, '0));
        send_word(make_word(KIND_ADD, 1'b1, R_AX, SRC_MEM, R_AL, BASE_DIRECT, 16'hFFFF,
                            '0, '0));
        send_word(make_word(KIND_CMP, 1'b1, R_AX, SRC_REG, R_AX, BASE_DIRECT, '0, '0, '0));
        send_word(make_word(KIND_JNE, 1'b1, R_AL, SRC_REG, R_AL, BASE_DIRECT, '0, '0,
                            16'h7FFF));
        send_word(make_word(KIND_SUB, 1'b0, R_AL, SRC_IMM8, R_AL, BASE_BX_SI, '0,
                            16'h0001, '0));
        send_word(make_word(KIND_JNE, 1'b1, R_AL, SRC_REG, R_AL, BASE_DIRECT, '0, '0,
                            16'h7FFF));
        send_word(make_word(KIND_JNE, 1'b1, R_AL, SRC_REG, R_AL, BASE_DIRECT, '0, '0,
                            16'h8000));
        send_word(make_word(KIND_JNE, 1'b1, R_AL, SRC_REG, R_AL, BASE_DIRECT, '0, '0,
                            16'h0001));
        send_word(make_word(KIND_ADD, 1'b0, R_AL, SRC_REG, R_AX, BASE_BP_DI, 16'h0002,
                            '0, '0));
        send_word(make_word(KIND_CMP, 1'b0, R_AL, SRC_REG, R_BH, BASE_BP_SI, 16'hFFFF,
                            '0, '0));
        send_word(make_word(KIND_MOV, 1'b0, R_AL, SRC_MEM, R_AL, BASE_BX_DI, '0, '0, '0));
        send_word(make_word(KIND_CMP, 1'b0, R_AL, SRC_MEM, R_AL, BASE_DI, 16'h0010,
                            '0, '0));
        send_word(make_word(KIND_NONE_LO, 1'b1, R_AX, SRC_IMM16, R_AL, BASE_DIRECT, '0,
                            16'h1234, 16'h0004));
        send_word(make_word(KIND_NONE_HI, 1'b0, R_AL, SRC_MEM, R_AL, BASE_SI, '0, '0,
                            16'hFFFF));
        send_word(make_word(KIND_MOV, 1'b1, R_CX, SRC_MEM, R_AL, BASE_NONE_HI, 16'hFFFF,
                            '0, '0));
        send_word(make_word(KIND_ADD, 1'b1, R_AL, SRC_IMM8, R_AL, BASE_DIRECT, '0,
                            16'h00FF, '0));
        send_word(make_word(KIND_SUB, 1'b1, R_DH, SRC_REG, R_DH, BASE_DIRECT, '0, '0, '0));
        send_word(make_word(KIND_MOV, 1'b0, R_AL, SRC_REG, R_DI, BASE_BP, 16'h0006,
                            '0, '0));
        send_word(make_word(KIND_ADD, 1'b1, R_BX, SRC_MEM, R_AL, BASE_BX, '0, '0, '0));
        drain_results();

        // Random part. A stretch in the middle starts no random idling on either side,
        // and every few hundred words the sender waits for the block to empty.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady = (n >= 500 && n < 700);
            if (n % 300 == 299) begin
                drain_results();
            end else if (!steady && $urandom_range(0, 99) < 5) begin
                idle_cycles($urandom_range(1, 4));
            end
            send_word(random_word());
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d instruction words, %0d of them faulting and %0d taken jumps;",
                 sb.words_seen, sb.faults_seen, sb.jumps_taken);
        $display("%0d results compared field by field, %0d mismatches.",
                 sb.results_seen, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
